[rtl/core/vnlb_pkg.sv]
// ----------------------------------------------------------------------------
// vnlb_pkg
// Shared types and codes of the Verlet neighbor list builder.
// ----------------------------------------------------------------------------
package vnlb_pkg;

  // Sizes fixed by the field widths of the channels.
  localparam int MAX_PARTICLES = 256;
  localparam int MAX_PAIRS     = 4096;
  localparam int COORD_BITS    = 24;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_PARTICLES = 2'd0;
  localparam logic [1:0] REG_MOBILE    = 2'd1;
  localparam logic [1:0] REG_BOX       = 2'd2;
  localparam logic [1:0] REG_CUTOFF    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_EVAL,
    ST_BLD_RD,
    ST_BLD_WAIT,
    ST_BLD_EVAL,
    ST_BLD_STORE,
    ST_RD_WAIT,
    ST_REPLY
  } state_t;

  // Control from the sequencer to the distance unit.
  typedef struct packed {
    logic start;
    logic scale_ten;
  } dist_ctrl_t;

endpackage

[rtl/core/vnlb_if.sv]
// ----------------------------------------------------------------------------
// vnlb_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface vnlb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/vnlb_ram.sv]
// ----------------------------------------------------------------------------
// vnlb_ram
// Single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vnlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/vnlb_dist.sv]
// ----------------------------------------------------------------------------
// vnlb_dist
// Pipelined scaled squared distance with periodic x wrap.
// ----------------------------------------------------------------------------
module vnlb_dist #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  vnlb_pkg::dist_ctrl_t    ctrl,
  input  logic [COORD_BITS-1:0]   ax,
  input  logic [COORD_BITS-1:0]   ay,
  input  logic [COORD_BITS-1:0]   bx,
  input  logic [COORD_BITS-1:0]   by,
  input  logic [COORD_BITS-1:0]   box,
  output logic [2*COORD_BITS+8:0] dist_sq,
  output logic                    done
);
  import vnlb_pkg::*;

  localparam int DW = COORD_BITS + 2;
  localparam int SW = COORD_BITS + 4;

  logic signed [DW-1:0] d, d2, w, dw;
  logic [COORD_BITS:0]  adx, ady;
  logic [SW-1:0]        sx, sy, sx_c, sy_c;
  logic [2*SW-1:0]      qx, qy;
  logic                 v1, v2;

  always_comb begin
    d = $signed({2'b00, ax}) - $signed({2'b00, bx});
    w = $signed({2'b00, box});
    d2 = d <<< 1;
    if (d2 >= w) begin
      dw = d - w;
    end else if (d2 <= -w) begin
      dw = d + w;
    end else begin
      dw = d;
    end
    adx = dw[DW-1] ? (COORD_BITS+1)'(0) - dw[COORD_BITS:0] : dw[COORD_BITS:0];
    ady = (ay >= by) ? {1'b0, ay - by} : {1'b0, by - ay};
    sx_c = ctrl.scale_ten ? (SW'(adx) << 3) + (SW'(adx) << 1) : (SW'(adx) << 2) + SW'(adx);
    sy_c = ctrl.scale_ten ? (SW'(ady) << 3) + (SW'(ady) << 1) : (SW'(ady) << 2) + SW'(ady);
  end

  always_ff @(posedge clk) begin
    v1   <= ctrl.start;
    v2   <= v1;
    done <= v2;
    sx   <= sx_c;
    sy   <= sy_c;
    qx   <= sx * sx;
    qy   <= sy * sy;
    dist_sq <= (2*COORD_BITS+9)'(qx) + (2*COORD_BITS+9)'(qy);
  end
endmodule

[rtl/core/verlet_neighbor_list_builder_unit.sv]
// ----------------------------------------------------------------------------
// verlet_neighbor_list_builder_unit
// 2D Verlet neighbor list builder with a periodic x axis.
// ----------------------------------------------------------------------------
// Usage: one word on the input channel carries a command. Load writes a
// particle position; build compares every pair n < mobile_count, n < m <
// particle_count and stores it when 25*d^2 < 36*rc^2; update rebuilds only
// when some mobile particle moved by rc/10 or more (or no build happened);
// read returns one stored pair. Each command returns exactly one result word.
// Config writes go through a separate channel, accepted only while idle.
// An update check runs each mobile particle in turn, a build each tested pair
// and then the particle_count positions of the saved copy, all through the
// single distance pipeline and the one-read-port position RAMs.
// One command is in flight at a time; the input is not ready until its
// result has been taken, so a stalled receiver holds the block.
// Reset clears the list count, the built and overflow flags and restores the
// register defaults; position and list RAMs are not cleared.
// ----------------------------------------------------------------------------
module verlet_neighbor_list_builder_unit (
  input logic clk,
  input logic rst,
  vnlb_stream_if.sink   in_ch,
  vnlb_stream_if.sink   cfg,
  vnlb_stream_if.source out_ch
);
  import vnlb_pkg::*;

  localparam int PB = $clog2(MAX_PARTICLES);
  localparam int LB = $clog2(MAX_PAIRS);
  localparam int DSW = 2*COORD_BITS + 9;

  // config registers
  logic [8:0]  particle_count, mobile_count;
  logic [23:0] box_width, cutoff_radius;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= 9'd2;
      mobile_count   <= 9'd1;
      box_width      <= 24'hFFFFFF;
      cutoff_radius  <= 24'd4096;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.index)
        REG_PARTICLES: particle_count <= cfg.data.value[8:0];
        REG_MOBILE:    mobile_count   <= cfg.data.value[8:0];
        REG_BOX:       box_width      <= cfg.data.value[23:0];
        REG_CUTOFF:    cutoff_radius  <= cfg.data.value[23:0];
        default: ;
      endcase
    end
  end
  // hold config writes while a command is in flight
  assign cfg.ready = (state == ST_IDLE);

  logic [COORD_BITS-1:0] box_c, rc_c;
  assign box_c = COORD_BITS'(box_width);
  assign rc_c  = COORD_BITS'(cutoff_radius);

  // effective counts
  logic [PB:0] np, nm;
  always_comb begin
    np = (32'(particle_count) > MAX_PARTICLES) ? (PB+1)'(MAX_PARTICLES)
                                               : (PB+1)'(particle_count);
    nm = (32'(mobile_count) > 32'(np)) ? np : (PB+1)'(mobile_count);
  end

  // limits, registered from the config registers (config is stable during a command)
  logic [DSW-1:0] lim_build, lim_move;
  logic [COORD_BITS+2:0] rc6;
  always_ff @(posedge clk) begin
    rc6 <= (COORD_BITS+3)'(rc_c) * (COORD_BITS+3)'(6);
    lim_build <= DSW'(rc6) * DSW'(rc6);
    lim_move  <= DSW'(rc_c) * DSW'(rc_c);
  end

  logic [PB-1:0] ld_idx;
  logic [COORD_BITS-1:0] ld_x, ld_y;
  logic [11:0] rd_idx;
  logic [PB:0] n, m;
  logic [LB:0] count;
  logic [LB:0] stored_pairs;
  logic list_built, overflowed, over_acc, rebuilt;
  logic [7:0] res_first, res_second;

  // position memories: current (A/B copies for two reads) and saved
  logic cur_we, sav_we, lst_we;
  logic [PB-1:0] cur_waddr, ra, rb, sav_addr;
  logic [COORD_BITS-1:0] cur_wx, cur_wy, ax, ay, bx, by, sx, sy;
  logic [LB-1:0] lst_waddr, lst_raddr;
  logic [7:0] lo_rd, hi_rd;

  vnlb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTICLES)) u_cxa (
    .clk, .we(cur_we), .waddr(cur_waddr), .wdata(cur_wx), .raddr(ra), .rdata(ax));
  vnlb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTICLES)) u_cya (
    .clk, .we(cur_we), .waddr(cur_waddr), .wdata(cur_wy), .raddr(ra), .rdata(ay));
  vnlb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTICLES)) u_cxb (
    .clk, .we(cur_we), .waddr(cur_waddr), .wdata(cur_wx), .raddr(rb), .rdata(bx));
  vnlb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTICLES)) u_cyb (
    .clk, .we(cur_we), .waddr(cur_waddr), .wdata(cur_wy), .raddr(rb), .rdata(by));
  vnlb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTICLES)) u_sx (
    .clk, .we(sav_we), .waddr(sav_addr), .wdata(bx), .raddr(ra), .rdata(sx));
  vnlb_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PARTICLES)) u_sy (
    .clk, .we(sav_we), .waddr(sav_addr), .wdata(by), .raddr(ra), .rdata(sy));
  vnlb_ram #(.WIDTH(8), .DEPTH(MAX_PAIRS)) u_lo (
    .clk, .we(lst_we), .waddr(lst_waddr), .wdata(8'(n)), .raddr(lst_raddr), .rdata(lo_rd));
  vnlb_ram #(.WIDTH(8), .DEPTH(MAX_PAIRS)) u_hi (
    .clk, .we(lst_we), .waddr(lst_waddr), .wdata(8'(m)), .raddr(lst_raddr), .rdata(hi_rd));

  dist_ctrl_t dctrl;
  logic [DSW-1:0] dsq;
  logic ddone;
  logic chk;  // check phase compares saved (A side) against current (B side)
  logic [COORD_BITS-1:0] pax, pay;

  assign pax = chk ? sx : ax;
  assign pay = chk ? sy : ay;

  vnlb_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk, .ctrl(dctrl), .ax(bx), .ay(by), .bx(pax), .by(pay), .box(box_c),
    .dist_sq(dsq), .done(ddone));

  // saved copy is written in the cycle after the b read is issued
  logic copy_v;
  logic [PB-1:0] copy_idx;
  logic copy_run;
  logic [PB:0] cp;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (cmd_t'(in_ch.data.command))
            CMD_LOAD:   state_next = ST_REPLY;
            CMD_BUILD:  state_next = ST_BLD_RD;
            CMD_UPDATE: state_next = ST_CHK_RD;
            default:    state_next = ST_RD_WAIT;
          endcase
        end
      end
      ST_CHK_RD: begin
        if (!list_built) state_next = ST_BLD_RD;
        else if (n >= nm) state_next = ST_REPLY;
        else state_next = ST_CHK_EVAL;
      end
      ST_CHK_EVAL: begin
        if (ddone) state_next = (dsq >= lim_move) ? ST_BLD_RD : ST_CHK_RD;
      end
      ST_BLD_RD: begin
        if (n >= nm || m >= np) state_next = ST_BLD_STORE;
        else state_next = ST_BLD_EVAL;
      end
      ST_BLD_EVAL: if (ddone) state_next = ST_BLD_WAIT;
      ST_BLD_WAIT: state_next = ST_BLD_RD;
      ST_BLD_STORE: if (!copy_run && !copy_v && cp >= np) state_next = ST_REPLY;
      ST_RD_WAIT: state_next = ST_REPLY;
      ST_REPLY: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    out_ch.valid = (state == ST_REPLY);
    cur_we = 1'b0;
    cur_waddr = ld_idx;
    cur_wx = ld_x;
    cur_wy = ld_y;
    ra = n[PB-1:0];
    rb = (state == ST_CHK_RD) ? n[PB-1:0] : m[PB-1:0];
    if (state == ST_BLD_STORE) rb = cp[PB-1:0];
    dctrl.start = 1'b0;
    dctrl.scale_ten = chk;
    lst_we = 1'b0;
    lst_waddr = count[LB-1:0];
    // issue the list read at the accepting edge so data is ready in ST_RD_WAIT
    lst_raddr = (state == ST_IDLE) ? LB'(in_ch.data.pair_index) : LB'(rd_idx);
    if (state == ST_IDLE && in_ch.valid && cmd_t'(in_ch.data.command) == CMD_LOAD &&
        32'(in_ch.data.particle_index) < MAX_PARTICLES) begin
      cur_we = 1'b1;
      cur_waddr = PB'(in_ch.data.particle_index);
      cur_wx = COORD_BITS'(in_ch.data.pos_x);
      cur_wy = COORD_BITS'(in_ch.data.pos_y);
    end
    dctrl.start = copy_v && (state == ST_CHK_EVAL || state == ST_BLD_EVAL);
    if (state == ST_BLD_WAIT && dsq < lim_build && count < (LB+1)'(MAX_PAIRS)) begin
      lst_we = 1'b1;
    end
  end

  assign sav_we = copy_run;
  assign sav_addr = copy_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stored_pairs <= '0;
      list_built <= 1'b0;
      overflowed <= 1'b0;
      copy_v <= 1'b0;
      copy_run <= 1'b0;
    end else begin
      state <= state_next;
      // copy_v marks the first eval cycle, when RAM data is valid
      copy_v <= (state == ST_CHK_RD && state_next == ST_CHK_EVAL) ||
                (state == ST_BLD_RD && state_next == ST_BLD_EVAL);
      copy_run <= (state == ST_BLD_STORE) && cp < np;
      copy_idx <= cp[PB-1:0];
      case (state)
        ST_IDLE: begin
          ld_idx <= PB'(in_ch.data.particle_index);
          ld_x <= COORD_BITS'(in_ch.data.pos_x);
          ld_y <= COORD_BITS'(in_ch.data.pos_y);
          rd_idx <= in_ch.data.pair_index;
          n <= '0;
          m <= (PB+1)'(1);
          count <= '0;
          over_acc <= 1'b0;
          cp <= '0;
          rebuilt <= 1'b0;
          chk <= (cmd_t'(in_ch.data.command) == CMD_UPDATE);
          res_first <= '0;
          res_second <= '0;
        end
        ST_CHK_RD: begin
          if (!list_built) chk <= 1'b0;
        end
        ST_CHK_EVAL: begin
          if (ddone) begin
            if (dsq >= lim_move) begin
              chk <= 1'b0;
              n <= '0;
              m <= (PB+1)'(1);
            end else begin
              n <= n + 1'b1;
            end
          end
        end
        ST_BLD_WAIT: begin
          if (dsq < lim_build) begin
            if (count < (LB+1)'(MAX_PAIRS)) count <= count + 1'b1;
            else over_acc <= 1'b1;
          end
          if (m + 1'b1 >= np) begin
            n <= n + 1'b1;
            m <= n + (PB+1)'(2);
          end else begin
            m <= m + 1'b1;
          end
        end
        ST_BLD_STORE: begin
          if (cp < np) cp <= cp + 1'b1;
          if (state_next == ST_REPLY) begin
            stored_pairs <= count;
            overflowed <= over_acc;
            list_built <= 1'b1;
            rebuilt <= 1'b1;
          end
        end
        ST_RD_WAIT: begin
          if ((LB+1)'(rd_idx) < stored_pairs) begin
            res_first <= lo_rd;
            res_second <= hi_rd;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_ch.data.pair_count    = 13'(stored_pairs);
    out_ch.data.rebuilt       = rebuilt;
    out_ch.data.list_overflow = overflowed;
    out_ch.data.pair_first    = res_first;
    out_ch.data.pair_second   = res_second;
  end
endmodule

[rtl/core/vnlb_checker.sv]
// ----------------------------------------------------------------------------
// vnlb_checker
// Port-level checks of the neighbor list builder.
// ----------------------------------------------------------------------------
module vnlb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] pair_count,
  input logic        rebuilt
);
  import vnlb_pkg::*;

  // one command in flight: no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  // stalled result holds its count
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pair_count)) else $error("result changed");
  // count never exceeds storage
  a_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pair_count <= 13'(MAX_PAIRS)) else $error("count too large");
  // after reset the block takes input
  a_rst: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid) else $error("not idle after reset");
  // count changes only with a rebuild
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    $changed(pair_count) && out_valid |-> rebuilt) else $error("count changed");
endmodule

bind verlet_neighbor_list_builder_unit vnlb_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .pair_count(out_ch.data.pair_count), .rebuilt(out_ch.data.rebuilt));
